// File: design/request_budget_limiter_defines.svh
// Assertion helpers used by request_budget_limiter.sv.
`ifndef REQUEST_BUDGET_LIMITER_DEFINES_SVH
`define REQUEST_BUDGET_LIMITER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RBL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("request_budget_limiter: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define RBL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("request_budget_limiter: next-cycle check failed");

`endif

// File: design/rbl_pkg.sv
`default_nettype none

package rbl_pkg;

	localparam int unsigned BYTE_W  = 64;
	localparam int unsigned PAGE_W  = 32;
	localparam int unsigned TICK_W  = 63;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		ACT_RESULT  = 2'd0,
		ACT_ADAPTER = 2'd1,
		ACT_PAGES   = 2'd2,
		ACT_CHECK   = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		ERR_OK            = 3'd0,
		ERR_CANCELLED     = 3'd1,
		ERR_DEADLINE      = 3'd2,
		ERR_RESULT_LIMIT  = 3'd3,
		ERR_ADAPTER_LIMIT = 3'd4,
		ERR_PAGE_LIMIT    = 3'd5,
		ERR_PAGE_SIZE     = 3'd6,
		ERR_OVERFLOW      = 3'd7
	} err_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_RESULT_BYTES  = 3'd0,
		CFG_MAX_ADAPTER_BYTES = 3'd1,
		CFG_MAX_PAGE_BYTES    = 3'd2,
		CFG_MAX_PAGES         = 3'd3,
		CFG_MAX_ELAPSED_TICKS = 3'd4,
		CFG_START_TICK        = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		act_t              action;
		logic [BYTE_W-1:0] amount;
		logic              cancel_flag;
		logic [TICK_W-1:0] now_tick;
	} req_t;

	typedef struct packed {
		err_t              error_code;
		logic [BYTE_W-1:0] expected_value;
		logic [BYTE_W-1:0] actual_value;
	} rsp_t;

	typedef struct packed {
		logic [BYTE_W-1:0] max_result_bytes;
		logic [BYTE_W-1:0] max_adapter_bytes;
		logic [BYTE_W-1:0] max_page_bytes;
		logic [PAGE_W-1:0] max_pages;
		logic [TICK_W-1:0] max_elapsed_ticks;
		logic [TICK_W-1:0] start_tick;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] result_bytes;
		logic [BYTE_W-1:0] adapter_bytes;
		logic [PAGE_W-1:0] pages;
	} tot_t;

	typedef struct packed {
		logic              result_we;
		logic              adapter_we;
		logic              page_we;
		logic [BYTE_W-1:0] byte_sum;
		logic [PAGE_W-1:0] page_sum;
	} upd_t;

endpackage

`default_nettype wire

// File: design/request_budget_limiter.sv
// Budget guard for one live request. Each item asks to reserve result bytes,
// adapter bytes or pages, or only to check the cancel flag and the deadline,
// and each item yields exactly one result with an error code and, on a limit
// or page-size failure, the limit and the attempted value. An item is
// registered on acceptance and evaluated in the following cycle; its result
// is registered once the output is free, so one item per cycle is sustained
// while rsp_ready holds; the result register stands between the two sides,
// so an item can be taken while the previous result still waits. The running
// totals update in the same cycle that an item's result is registered, so
// the next item sees them at once. The user must write registers through the
// plain write port only while no item is in flight; nothing enforces it.
`default_nettype none

module request_budget_limiter
	import rbl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data
);

`include "request_budget_limiter_defines.svh"

	cfg_t cfg_q;
	tot_t tot_q;
	logic valid_s1;
	req_t item_s1;
	rsp_t eval_rsp;
	upd_t eval_upd;
	logic adv_s1;

	assign adv_s1    = valid_s1 && (!rsp_valid || rsp_ready);
	assign req_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_RESULT_BYTES:  cfg_q.max_result_bytes  <= cfg_data;
				CFG_MAX_ADAPTER_BYTES: cfg_q.max_adapter_bytes <= cfg_data;
				CFG_MAX_PAGE_BYTES:    cfg_q.max_page_bytes    <= cfg_data;
				CFG_MAX_PAGES:         cfg_q.max_pages         <= cfg_data[PAGE_W-1:0];
				CFG_MAX_ELAPSED_TICKS: cfg_q.max_elapsed_ticks <= cfg_data[TICK_W-1:0];
				CFG_START_TICK:        cfg_q.start_tick        <= cfg_data[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			item_s1 <= req;
		end
	end

	rbl_eval u_eval (
		.item (item_s1),
		.cfg  (cfg_q),
		.tot  (tot_q),
		.rsp  (eval_rsp),
		.upd  (eval_upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q <= '0;
		end else if (adv_s1) begin
			if (eval_upd.result_we) begin
				tot_q.result_bytes <= eval_upd.byte_sum;
			end
			if (eval_upd.adapter_we) begin
				tot_q.adapter_bytes <= eval_upd.byte_sum;
			end
			if (eval_upd.page_we) begin
				tot_q.pages <= eval_upd.page_sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp <= eval_rsp;
		end
	end

	`RBL_ASSERT_NEXT(a_totals_hold, !adv_s1, $stable(tot_q))
	`RBL_ASSERT_NEXT(a_fail_no_update, adv_s1 && (eval_rsp.error_code != ERR_OK),
		$stable(tot_q))
	`RBL_ASSERT_NEXT(a_pages_in_limit, adv_s1 && eval_upd.page_we,
		tot_q.pages <= cfg_q.max_pages)
	`RBL_ASSERT_NOW(a_stall_blocks_input, valid_s1 && rsp_valid && !rsp_ready, !req_ready)
	`RBL_ASSERT_NOW(a_gate_codes_zero,
		rsp_valid && ((rsp.error_code == ERR_OK) || (rsp.error_code == ERR_CANCELLED) ||
		(rsp.error_code == ERR_DEADLINE)),
		(rsp.expected_value == '0) && (rsp.actual_value == '0))

endmodule

`default_nettype wire

// File: design/rbl_eval.sv
`default_nettype none

module rbl_eval
	import rbl_pkg::*;
(
	input  req_t item,
	input  cfg_t cfg,
	input  tot_t tot,
	output rsp_t rsp,
	output upd_t upd
);

	logic [TICK_W:0]   deadline_sum;
	logic [TICK_W-1:0] deadline;
	logic              late;
	logic [BYTE_W-1:0] byte_total;
	logic [BYTE_W-1:0] byte_limit;
	logic [BYTE_W:0]   byte_sum;
	logic [PAGE_W:0]   page_sum;
	err_t              limit_code;

	assign deadline_sum = {1'b0, cfg.start_tick} + {1'b0, cfg.max_elapsed_ticks};
	assign deadline     = deadline_sum[TICK_W] ? {TICK_W{1'b1}} : deadline_sum[TICK_W-1:0];
	assign late         = (item.now_tick < cfg.start_tick) || (item.now_tick > deadline);

	assign byte_total = (item.action == ACT_ADAPTER) ? tot.adapter_bytes : tot.result_bytes;
	assign byte_limit = (item.action == ACT_ADAPTER) ? cfg.max_adapter_bytes
	                                                 : cfg.max_result_bytes;
	assign limit_code = (item.action == ACT_ADAPTER) ? ERR_ADAPTER_LIMIT : ERR_RESULT_LIMIT;
	assign byte_sum   = {1'b0, byte_total} + {1'b0, item.amount};
	assign page_sum   = {1'b0, tot.pages} + {1'b0, item.amount[PAGE_W-1:0]};

	always_comb begin
		rsp.error_code     = ERR_OK;
		rsp.expected_value = '0;
		rsp.actual_value   = '0;
		upd.result_we      = 1'b0;
		upd.adapter_we     = 1'b0;
		upd.page_we        = 1'b0;
		upd.byte_sum       = byte_sum[BYTE_W-1:0];
		upd.page_sum       = page_sum[PAGE_W-1:0];
		if ((item.action == ACT_ADAPTER) && (item.amount > cfg.max_page_bytes)) begin
			rsp.error_code     = ERR_PAGE_SIZE;
			rsp.expected_value = cfg.max_page_bytes;
			rsp.actual_value   = item.amount;
		end else if (item.cancel_flag) begin
			rsp.error_code = ERR_CANCELLED;
		end else if (late) begin
			rsp.error_code = ERR_DEADLINE;
		end else begin
			case (item.action)
				ACT_RESULT, ACT_ADAPTER: begin
					if (byte_sum[BYTE_W]) begin
						rsp.error_code     = ERR_OVERFLOW;
						rsp.expected_value = byte_total;
						rsp.actual_value   = item.amount;
					end else if (byte_sum[BYTE_W-1:0] > byte_limit) begin
						rsp.error_code     = limit_code;
						rsp.expected_value = byte_limit;
						rsp.actual_value   = byte_sum[BYTE_W-1:0];
					end else begin
						upd.result_we  = (item.action == ACT_RESULT);
						upd.adapter_we = (item.action == ACT_ADAPTER);
					end
				end
				ACT_PAGES: begin
					if (page_sum > {1'b0, cfg.max_pages}) begin
						rsp.error_code     = ERR_PAGE_LIMIT;
						rsp.expected_value = {{(BYTE_W-PAGE_W){1'b0}}, cfg.max_pages};
						rsp.actual_value   = {{(BYTE_W-PAGE_W-1){1'b0}}, page_sum};
					end else begin
						upd.page_we = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire
